/* src/gtm_pkg.sv */
// Shared constants and types for the global tone map pixel block.
// No dependencies; imported by global_tone_map_pixel and gtm_checker.
package gtm_pkg;

    localparam int unsigned TABLE_ENTRIES = 257;
    localparam int unsigned TABLE_AW      = $clog2(TABLE_ENTRIES);
    localparam int unsigned GAIN_W        = 13;
    localparam int unsigned SAMPLE_W      = 16;
    localparam int unsigned S14_W         = 14;
    localparam int unsigned DROP_BITS     = SAMPLE_W - S14_W;
    localparam int unsigned WEIGHT_W      = 10;
    localparam int unsigned FRAC_SHIFT    = 10;
    localparam int unsigned SEG_BITS      = 6;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = WEIGHT_W;
    localparam int unsigned PIPE_LAT      = 6;

    localparam logic [S14_W-1:0] MAX14 = {S14_W{1'b1}};
    localparam logic [TABLE_AW-1:0] LAST_ENTRY = TABLE_AW'(TABLE_ENTRIES - 1);

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYPASS       = 2'd0,
        CFG_WEIGHT_RED   = 2'd1,
        CFG_WEIGHT_GREEN = 2'd2,
        CFG_WEIGHT_BLUE  = 2'd3
    } t_cfg_idx;

    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_RED   = 10'd306;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_GREEN = 10'd601;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_BLUE  = 10'd117;

    typedef struct packed {
        logic [S14_W-1:0] red;
        logic [S14_W-1:0] green;
        logic [S14_W-1:0] blue;
    } t_rgb14;

endpackage

/* src/global_tone_map_pixel.sv */
// Top level of the global tone map pixel block: luma, gain table lookup, gain apply or bypass.
// Depends on gtm_pkg and gtm_ram.
//
//  channel   direction  handshake                signals
//  command   in         start & !busy            i_cmd, i_*_in, i_entry_index, i_entry_gain
//  result    out        o_valid strobe, 1 cycle  o_red_out, o_green_out, o_blue_out
//  config    in         i_cfg_we, no wait        i_cfg_idx, i_cfg_data
//
// One transaction per clock; busy is never raised. After acceptance a pixel result passes
// through registered stages: input register, weight products, luma + table read,
// interpolation, gain products and output.
// Table writes take effect in the same pipeline slot as the table read, so order holds.
// Sync active-low reset clears valids, sets default config; table undefined until written.
module global_tone_map_pixel
    import gtm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_cmd,
    input  logic [SAMPLE_W-1:0]   i_red_in,
    input  logic [SAMPLE_W-1:0]   i_green_in,
    input  logic [SAMPLE_W-1:0]   i_blue_in,
    input  logic [TABLE_AW-1:0]   i_entry_index,
    input  logic [GAIN_W-1:0]     i_entry_gain,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [SAMPLE_W-1:0]   o_red_out,
    output logic [SAMPLE_W-1:0]   o_green_out,
    output logic [SAMPLE_W-1:0]   o_blue_out
);

    localparam int unsigned WPROD_W = S14_W + WEIGHT_W;        // 24
    localparam int unsigned YSUM_W  = WPROD_W + 2;             // 26
    localparam int unsigned DIFF_W  = GAIN_W + 1;              // 14 signed
    localparam int unsigned FPROD_W = DIFF_W + SEG_BITS;       // 20 signed
    localparam int unsigned GPROD_W = S14_W + GAIN_W;          // 27

    // configuration
    logic                r_bypass;
    logic [WEIGHT_W-1:0] r_wr, r_wg, r_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b0;
            r_wr     <= RST_WEIGHT_RED;
            r_wg     <= RST_WEIGHT_GREEN;
            r_wb     <= RST_WEIGHT_BLUE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BYPASS:       r_bypass <= i_cfg_data[0];
                CFG_WEIGHT_RED:   r_wr     <= i_cfg_data;
                CFG_WEIGHT_GREEN: r_wg     <= i_cfg_data;
                CFG_WEIGHT_BLUE:  r_wb     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic accept;
    assign accept = i_start && !o_busy;

    // valid pipeline
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_vout;
    logic r_wr1, r_wr2;   // table write in stage 1 / 2

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_wr1  <= 1'b0;
            r_v2   <= 1'b0;
            r_wr2  <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_vout <= 1'b0;
        end else begin
            r_v1   <= accept && (t_cmd'(i_cmd) == CMD_PIXEL);
            r_wr1  <= accept && (t_cmd'(i_cmd) == CMD_WRITE);
            r_v2   <= r_v1;
            r_wr2  <= r_wr1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v5   <= r_v4;
            r_vout <= r_v5;
        end
    end

    // stage 1: truncated samples, write payload
    t_rgb14              r_s1_pix;
    logic [TABLE_AW-1:0] r_s1_idx;
    logic [GAIN_W-1:0]   r_s1_gain;

    always_ff @(posedge i_clk) begin
        r_s1_pix.red   <= i_red_in[SAMPLE_W-1:DROP_BITS];
        r_s1_pix.green <= i_green_in[SAMPLE_W-1:DROP_BITS];
        r_s1_pix.blue  <= i_blue_in[SAMPLE_W-1:DROP_BITS];
        r_s1_idx       <= i_entry_index;
        r_s1_gain      <= i_entry_gain;
    end

    // stage 2: weighted products
    t_rgb14              r_s2_pix;
    logic [WPROD_W-1:0]  r_pr, r_pg, r_pb;
    logic [TABLE_AW-1:0] r_s2_idx;
    logic [GAIN_W-1:0]   r_s2_gain;

    always_ff @(posedge i_clk) begin
        r_s2_pix  <= r_s1_pix;
        r_pr      <= WPROD_W'(r_s1_pix.red)   * WPROD_W'(r_wr);
        r_pg      <= WPROD_W'(r_s1_pix.green) * WPROD_W'(r_wg);
        r_pb      <= WPROD_W'(r_s1_pix.blue)  * WPROD_W'(r_wb);
        r_s2_idx  <= r_s1_idx;
        r_s2_gain <= r_s1_gain;
    end

    // stage 2 comb: luma, table addresses
    logic [YSUM_W-1:0]   ysum;
    logic [S14_W-1:0]    luma;
    logic [TABLE_AW-1:0] addr_lo, addr_hi;
    logic                tbl_we;

    always_comb begin
        ysum = YSUM_W'(r_pr) + YSUM_W'(r_pg) + YSUM_W'(r_pb) + YSUM_W'(1 << (FRAC_SHIFT - 1));
        if (|ysum[YSUM_W-1:FRAC_SHIFT+S14_W]) begin
            luma = MAX14;
        end else begin
            luma = ysum[FRAC_SHIFT+S14_W-1:FRAC_SHIFT];
        end
        addr_lo = TABLE_AW'(luma[S14_W-1:SEG_BITS]);
        addr_hi = addr_lo + TABLE_AW'(1);
        if (addr_hi > LAST_ENTRY) begin
            addr_hi = LAST_ENTRY;
        end
        tbl_we = r_wr2 && (r_s2_idx <= LAST_ENTRY);
    end

    logic [GAIN_W-1:0] g_lo, g_hi;

    gtm_ram #(.WIDTH(GAIN_W), .DEPTH(TABLE_ENTRIES)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_s2_idx),
        .i_wdata (r_s2_gain),
        .i_raddr (addr_lo),
        .o_rdata (g_lo)
    );

    gtm_ram #(.WIDTH(GAIN_W), .DEPTH(TABLE_ENTRIES)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_s2_idx),
        .i_wdata (r_s2_gain),
        .i_raddr (addr_hi),
        .o_rdata (g_hi)
    );

    // stage 3: table data arrives
    t_rgb14              r_s3_pix;
    logic [SEG_BITS-1:0] r_s3_frac;

    always_ff @(posedge i_clk) begin
        r_s3_pix  <= r_s2_pix;
        r_s3_frac <= luma[SEG_BITS-1:0];
    end

    logic signed [DIFF_W-1:0] gdiff;
    assign gdiff = $signed({1'b0, g_hi}) - $signed({1'b0, g_lo});

    // stage 4: fraction times slope
    t_rgb14                     r_s4_pix;
    logic signed [FPROD_W-1:0]  r_fprod;
    logic [GAIN_W-1:0]          r_s4_g1;

    always_ff @(posedge i_clk) begin
        r_s4_pix <= r_s3_pix;
        r_fprod  <= $signed({{(FPROD_W-SEG_BITS){1'b0}}, r_s3_frac}) *
                    FPROD_W'(gdiff);
        r_s4_g1  <= g_lo;
    end

    // signed divide by segment length, truncating toward zero
    logic signed [FPROD_W-1:0] fadj;
    logic signed [FPROD_W-1:0] step;
    logic signed [DIFF_W:0]    gsum;
    logic [GAIN_W-1:0]         gain;

    always_comb begin
        fadj = r_fprod;
        if (r_fprod[FPROD_W-1]) begin
            fadj = r_fprod + FPROD_W'((1 << SEG_BITS) - 1);
        end
        step = fadj >>> SEG_BITS;
        gsum = $signed({2'b00, r_s4_g1}) + $signed(step[DIFF_W:0]);
        gain = gsum[GAIN_W-1:0];
    end

    // stage 5: channel times gain
    t_rgb14             r_s5_pix;
    logic [GPROD_W-1:0] r_gr, r_gg, r_gb;

    always_ff @(posedge i_clk) begin
        r_s5_pix <= r_s4_pix;
        r_gr     <= GPROD_W'(r_s4_pix.red)   * GPROD_W'(gain);
        r_gg     <= GPROD_W'(r_s4_pix.green) * GPROD_W'(gain);
        r_gb     <= GPROD_W'(r_s4_pix.blue)  * GPROD_W'(gain);
    end

    function automatic logic [S14_W-1:0] round_clamp(input logic [GPROD_W-1:0] p);
        logic [GPROD_W:0] t;
        t = {1'b0, p} + (GPROD_W+1)'(1 << (FRAC_SHIFT - 1));
        if (|t[GPROD_W:FRAC_SHIFT+S14_W]) begin
            return MAX14;
        end
        return t[FRAC_SHIFT+S14_W-1:FRAC_SHIFT];
    endfunction

    t_rgb14 n_out;
    t_rgb14 r_out;

    always_comb begin
        if (r_bypass) begin
            n_out = r_s5_pix;
        end else begin
            n_out.red   = round_clamp(r_gr);
            n_out.green = round_clamp(r_gg);
            n_out.blue  = round_clamp(r_gb);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid     = r_vout;
    assign o_red_out   = {r_out.red,   {DROP_BITS{1'b0}}};
    assign o_green_out = {r_out.green, {DROP_BITS{1'b0}}};
    assign o_blue_out  = {r_out.blue,  {DROP_BITS{1'b0}}};

endmodule

/* src/gtm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gtm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/gtm_checker.sv */
// Port-level checker for global_tone_map_pixel, bound to the top level.
// Depends on gtm_pkg.
module gtm_checker
    import gtm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input logic                i_cmd,
    input logic                o_valid,
    input logic [SAMPLE_W-1:0] o_red_out,
    input logic [SAMPLE_W-1:0] o_green_out,
    input logic [SAMPLE_W-1:0] o_blue_out
);

    // every pixel transaction yields exactly one result after the fixed latency
    a_pixel_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (t_cmd'(i_cmd) == CMD_PIXEL)) |-> ##PIPE_LAT o_valid)
        else $error("pixel transaction produced no result");

    // no result without a pixel transaction at the right distance
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_rst_n && i_start && !o_busy &&
                          (t_cmd'(i_cmd) == CMD_PIXEL), PIPE_LAT))
        else $error("result without matching pixel transaction");

    // table writes never produce a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (t_cmd'(i_cmd) == CMD_WRITE)) |-> ##PIPE_LAT !o_valid)
        else $error("table write produced a result");

    // results are 14-bit values shifted up
    a_low_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red_out[DROP_BITS-1:0] == '0) && (o_green_out[DROP_BITS-1:0] == '0) &&
                    (o_blue_out[DROP_BITS-1:0] == '0))
        else $error("result low bits not zero");

endmodule

bind global_tone_map_pixel gtm_checker u_gtm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_cmd       (i_cmd),
    .o_valid     (o_valid),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out)
);
